FILE: design/adlp_pkg.sv
// adlp_pkg: shared types and constants for the adaptive degree line prefetcher
// used by adlp_table and adaptive_degree_line_prefetcher_unit
package adlp_pkg;

   localparam int TABLE_DEPTH_DEFAULT = 1024;
   localparam int LINE_W   = 64;
   localparam int DEG_W    = 7;
   localparam int TRIG_W   = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;

   localparam logic [DEG_W-1:0]  DEGREE_RESET  = 7'd1;
   localparam logic [TRIG_W-1:0] TRIGGER_RESET = 4'd2;
   localparam logic [DEG_W-1:0]  DOUBLE_LIMIT_RESET = 7'd60;
   localparam logic [TRIG_W-1:0] TRIGGER_CAP_RESET  = 4'd10;
   localparam logic [TRIG_W-1:0] TRIGGER_MAX  = 4'd15;
   localparam logic [DEG_W-1:0]  DEG_SAT      = 7'd127;

   // floor(x / 10) == (x * 1639) >> 14 for every x below 2730
   localparam logic [10:0] RECIP_TEN = 11'd1639;
   localparam int          RECIP_SHIFT = 14;

   localparam logic [CSR_IDX_W-1:0] CSR_DOUBLE_LIMIT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TRIGGER_CAP  = 2'd1;

   localparam logic [1:0] MODE_HIT  = 2'd0;
   localparam logic [1:0] MODE_MISS = 2'd1;
   localparam logic [1:0] MODE_FILL = 2'd2;
   localparam logic [1:0] MODE_NONE = 2'd3;

   typedef struct packed {
      logic [LINE_W-1:0] line;
      logic [LINE_W-1:0] issuer;
      logic              is_last;
      logic [DEG_W-1:0]  degree;
      logic [DEG_W-1:0]  trig_dist;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_HIT_THR,
      ST_HIT_WIN,
      ST_DIST_MUL,
      ST_DIST_SAT,
      ST_RUN,
      ST_HIT_L2
   } state_type;

endpackage

FILE: design/adlp_table.sv
// adlp_table: one-write, one-read synchronous table of prefetch entries
// depends on adlp_pkg for the entry layout
module adlp_table #(
   parameter int DEPTH = adlp_pkg::TABLE_DEPTH_DEFAULT,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  adlp_pkg::entry_type wr_data,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   output adlp_pkg::entry_type rd_data
);

   adlp_pkg::entry_type mem [DEPTH];
   adlp_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/adaptive_degree_line_prefetcher_unit.sv
// adaptive_degree_line_prefetcher_unit: sequential line prefetcher, top level
// depends on adlp_pkg and adlp_table
// sequence: a miss result is registered and shows in the cycle after accept; the
//   unit then records the run. a hit scans the filled entries (one per cycle
//   through the table read port), then checks the trigger window of the match.
// events: one at a time; busy stays high until the event is done.
// reset: fill count, replace pointer, degree 1, trigger 2 tenths; table data is
//   not cleared, the fill count marks valid entries, so no clearing pass.
module adaptive_degree_line_prefetcher_unit #(
   parameter int TABLE_DEPTH = adlp_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [1:0]                        req_mode,
   input  logic [63:0]                       req_addr,
   input  logic                              req_fill_was_prefetch,
   input  logic [63:0]                       req_evicted_addr,
   output logic                              rsp_valid,
   output logic [63:0]                       rsp_base_addr,
   output logic [63:0]                       rsp_target_addr,
   output logic                              rsp_fill_level,
   output logic                              rsp_last_of_run,
   input  logic                              csr_write_enable,
   input  logic [adlp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [adlp_pkg::CSR_DATA_W-1:0]   csr_write_data
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
   localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_DEPTH - 1);
   localparam int RECIP_SHIFT_L = adlp_pkg::RECIP_SHIFT;

   adlp_pkg::state_type state_ff, state_in;

   logic [6:0]  cd_ff, cd_in;
   logic [3:0]  tt_ff, tt_in;
   logic [6:0]  dlim_ff;
   logic [3:0]  tcap_ff;
   logic [CW-1:0] fill_ff, fill_in;
   logic [AW-1:0] rp_ff, rp_in;
   logic [CW-1:0] scan_ff, scan_in;
   logic          pend_ff, pend_in;
   logic [AW-1:0] pidx_ff, pidx_in;
   logic          found_ff, found_in;

   logic [1:0]  mode_ff, mode_in;
   logic        wpf_ff, wpf_in;
   logic [63:0] line_ff, line_in;
   logic [63:0] evl_ff, evl_in;
   logic [63:0] issuer_ff, issuer_in;
   logic        after_l2_ff, after_l2_in;

   logic [63:0] m_line_ff, m_line_in;
   logic [63:0] m_issuer_ff, m_issuer_in;
   logic        m_last_ff, m_last_in;
   logic [6:0]  m_deg_ff, m_deg_in;
   logic [6:0]  m_dist_ff, m_dist_in;
   logic [63:0] thr_ff, thr_in;
   logic [63:0] base_ff, base_in;

   logic [10:0] prod_ff, prod_in;
   logic [6:0]  dist_ff, dist_in;
   logic [7:0]  j_ff, j_in;

   logic        rv_ff, rv_in;
   logic [63:0] rb_ff, rb_in;
   logic [63:0] rt_ff, rt_in;
   logic        rl_ff, rl_in;
   logic        rlast_ff, rlast_in;

   logic                wr_en, rd_en;
   logic [AW-1:0]       wr_addr;
   adlp_pkg::entry_type wr_data, rd_data;

   logic        issue, hit_match, ev_match, pf_match;
   logic [7:0]  g1;
   logic [21:0] recip;

   adlp_table #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (scan_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   assign issue     = (state_ff == adlp_pkg::ST_SCAN) && (scan_ff < fill_ff);
   assign hit_match = pend_ff && (rd_data.line == line_ff);
   assign ev_match  = pend_ff && (rd_data.line == evl_ff) && rd_data.is_last;
   assign pf_match  = pend_ff && wpf_ff && !found_ff && (rd_data.line == line_ff);
   assign g1        = ({1'b0, rd_data.trig_dist} + 8'd1 > {1'b0, adlp_pkg::DEG_SAT})
                      ? {1'b0, adlp_pkg::DEG_SAT} : {1'b0, rd_data.trig_dist} + 8'd1;
   assign recip     = 22'(prod_ff) * 22'(adlp_pkg::RECIP_TEN);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         adlp_pkg::ST_IDLE: begin
            if (start) begin
               unique case (req_mode)
                  adlp_pkg::MODE_MISS: state_in = adlp_pkg::ST_DIST_MUL;
                  adlp_pkg::MODE_HIT, adlp_pkg::MODE_FILL: state_in = adlp_pkg::ST_SCAN;
                  default: state_in = adlp_pkg::ST_IDLE;
               endcase
            end
         end
         adlp_pkg::ST_SCAN: begin
            if (mode_ff == adlp_pkg::MODE_HIT && hit_match) begin
               state_in = adlp_pkg::ST_HIT_THR;
            end else if (!pend_ff && !issue) begin
               state_in = adlp_pkg::ST_IDLE;
            end
         end
         adlp_pkg::ST_HIT_THR: state_in = adlp_pkg::ST_HIT_WIN;
         adlp_pkg::ST_HIT_WIN: begin
            if (m_line_ff >= thr_ff) begin
               state_in = adlp_pkg::ST_DIST_MUL;
            end else if (m_last_ff) begin
               state_in = adlp_pkg::ST_HIT_L2;
            end else begin
               state_in = adlp_pkg::ST_IDLE;
            end
         end
         adlp_pkg::ST_DIST_MUL: state_in = adlp_pkg::ST_DIST_SAT;
         adlp_pkg::ST_DIST_SAT: state_in = adlp_pkg::ST_RUN;
         adlp_pkg::ST_RUN: begin
            if (j_ff > {1'b0, cd_ff}) begin
               state_in = after_l2_ff ? adlp_pkg::ST_HIT_L2 : adlp_pkg::ST_IDLE;
            end
         end
         adlp_pkg::ST_HIT_L2: state_in = adlp_pkg::ST_IDLE;
         default: state_in = adlp_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      cd_in = cd_ff;  tt_in = tt_ff;
      fill_in = fill_ff;  rp_in = rp_ff;
      scan_in = scan_ff;  pend_in = 1'b0;  pidx_in = pidx_ff;  found_in = found_ff;
      mode_in = mode_ff;  wpf_in = wpf_ff;  line_in = line_ff;  evl_in = evl_ff;
      issuer_in = issuer_ff;  after_l2_in = after_l2_ff;
      m_line_in = m_line_ff;  m_issuer_in = m_issuer_ff;  m_last_in = m_last_ff;
      m_deg_in = m_deg_ff;  m_dist_in = m_dist_ff;
      thr_in = thr_ff;  base_in = base_ff;
      prod_in = prod_ff;  dist_in = dist_ff;  j_in = j_ff;
      rv_in = 1'b0;  rb_in = rb_ff;  rt_in = rt_ff;  rl_in = rl_ff;  rlast_in = rlast_ff;
      wr_en = 1'b0;  wr_addr = pidx_ff;  wr_data = rd_data;
      rd_en = 1'b0;

      unique case (state_ff)
         adlp_pkg::ST_IDLE: begin
            if (start) begin
               mode_in  = req_mode;
               wpf_in   = req_fill_was_prefetch;
               line_in  = {6'd0, req_addr[63:6]};
               evl_in   = {6'd0, req_evicted_addr[63:6]};
               scan_in  = '0;
               found_in = 1'b0;
               if (req_mode == adlp_pkg::MODE_MISS) begin
                  rv_in       = 1'b1;
                  rb_in       = req_addr;
                  rt_in       = ({6'd0, req_addr[63:6]} + 64'(cd_ff)) << 6;
                  rl_in       = 1'b1;
                  rlast_in    = 1'b1;
                  issuer_in   = {6'd0, req_addr[63:6]};
                  after_l2_in = 1'b0;
               end
            end
         end
         adlp_pkg::ST_SCAN: begin
            if (issue && !(mode_ff == adlp_pkg::MODE_HIT && hit_match)) begin
               rd_en   = 1'b1;
               pend_in = 1'b1;
               pidx_in = scan_ff[AW-1:0];
               scan_in = scan_ff + CW'(1);
            end
            if (mode_ff == adlp_pkg::MODE_HIT && hit_match) begin
               m_line_in   = rd_data.line;
               m_issuer_in = rd_data.issuer;
               m_last_in   = rd_data.is_last;
               m_deg_in    = rd_data.degree;
               m_dist_in   = rd_data.trig_dist;
            end
            if (mode_ff == adlp_pkg::MODE_FILL) begin
               if (ev_match) begin
                  if (cd_ff > 7'd1) cd_in = cd_ff - 7'd1;
                  if (tt_ff >= 4'd1) tt_in = tt_ff - 4'd1;
               end
               if (pf_match) begin
                  found_in = 1'b1;
                  if (rd_data.is_last && (g1 > {1'b0, rd_data.degree})) begin
                     wr_en          = 1'b1;
                     wr_data.degree = g1[6:0];
                  end
               end
            end
         end
         adlp_pkg::ST_HIT_THR: begin
            thr_in  = m_issuer_ff + 64'(m_deg_ff) - 64'(m_dist_ff);
            base_in = m_issuer_ff + 64'(m_deg_ff);
         end
         adlp_pkg::ST_HIT_WIN: begin
            if (m_line_ff >= thr_ff) begin
               rv_in       = 1'b1;
               rb_in       = base_ff << 6;
               rt_in       = (base_ff + 64'(cd_ff)) << 6;
               rl_in       = 1'b1;
               rlast_in    = !m_last_ff;
               issuer_in   = base_ff;
               after_l2_in = m_last_ff;
            end
         end
         adlp_pkg::ST_DIST_MUL: begin
            prod_in = 11'(tt_ff) * 11'(cd_ff);
            j_in    = 8'd1;
         end
         adlp_pkg::ST_DIST_SAT: begin
            dist_in = (recip[21:RECIP_SHIFT_L] > 8'(adlp_pkg::DEG_SAT))
                      ? adlp_pkg::DEG_SAT : recip[RECIP_SHIFT_L+6:RECIP_SHIFT_L];
         end
         adlp_pkg::ST_RUN: begin
            if (j_ff <= {1'b0, cd_ff}) begin
               wr_en             = 1'b1;
               wr_data.line      = issuer_ff + 64'(j_ff);
               wr_data.issuer    = issuer_ff;
               wr_data.is_last   = (j_ff == {1'b0, cd_ff});
               wr_data.degree    = cd_ff;
               wr_data.trig_dist = dist_ff;
               j_in              = j_ff + 8'd1;
               if (fill_ff < DEPTH_C) begin
                  wr_addr = fill_ff[AW-1:0];
                  fill_in = fill_ff + CW'(1);
               end else begin
                  wr_addr = rp_ff;
                  rp_in   = (rp_ff == LAST_IDX) ? '0 : rp_ff + AW'(1);
               end
            end
         end
         adlp_pkg::ST_HIT_L2: begin
            rv_in    = 1'b1;
            rb_in    = (m_line_ff + 64'd1) << 6;
            rt_in    = (m_line_ff + 64'(cd_ff)) << 6;
            rl_in    = 1'b0;
            rlast_in = 1'b1;
            if (cd_ff < dlim_ff) cd_in = {cd_ff[5:0], 1'b0};
            if (tt_ff < tcap_ff && tt_ff < adlp_pkg::TRIGGER_MAX) tt_in = tt_ff + 4'd1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= adlp_pkg::ST_IDLE;
         cd_ff    <= adlp_pkg::DEGREE_RESET;
         tt_ff    <= adlp_pkg::TRIGGER_RESET;
         dlim_ff  <= adlp_pkg::DOUBLE_LIMIT_RESET;
         tcap_ff  <= adlp_pkg::TRIGGER_CAP_RESET;
         fill_ff  <= '0;
         rp_ff    <= '0;
         pend_ff  <= 1'b0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         cd_ff    <= cd_in;
         tt_ff    <= tt_in;
         fill_ff  <= fill_in;
         rp_ff    <= rp_in;
         pend_ff  <= pend_in;
         rv_ff    <= rv_in;
         if (csr_write_enable) begin
            if (csr_index == adlp_pkg::CSR_DOUBLE_LIMIT) dlim_ff <= csr_write_data;
            if (csr_index == adlp_pkg::CSR_TRIGGER_CAP)  tcap_ff <= csr_write_data[3:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      scan_ff     <= scan_in;
      pidx_ff     <= pidx_in;
      found_ff    <= found_in;
      mode_ff     <= mode_in;
      wpf_ff      <= wpf_in;
      line_ff     <= line_in;
      evl_ff      <= evl_in;
      issuer_ff   <= issuer_in;
      after_l2_ff <= after_l2_in;
      m_line_ff   <= m_line_in;
      m_issuer_ff <= m_issuer_in;
      m_last_ff   <= m_last_in;
      m_deg_ff    <= m_deg_in;
      m_dist_ff   <= m_dist_in;
      thr_ff      <= thr_in;
      base_ff     <= base_in;
      prod_ff     <= prod_in;
      dist_ff     <= dist_in;
      j_ff        <= j_in;
      rb_ff       <= rb_in;
      rt_ff       <= rt_in;
      rl_ff       <= rl_in;
      rlast_ff    <= rlast_in;
   end

   assign busy            = (state_ff != adlp_pkg::ST_IDLE);
   assign rsp_valid       = rv_ff;
   assign rsp_base_addr   = rb_ff;
   assign rsp_target_addr = rt_ff;
   assign rsp_fill_level  = rl_ff;
   assign rsp_last_of_run = rlast_ff;

`ifndef ASSERT_OFF
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == adlp_pkg::ST_IDLE && !start) |=> !rsp_valid)
      else $error("result beat without an event");
   a_first_beat_records: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last_of_run) |-> (state_ff == adlp_pkg::ST_DIST_MUL))
      else $error("non-final beat not followed by a run");
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= DEPTH_C)
      else $error("fill count beyond table depth");
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == adlp_pkg::ST_SCAN) |-> (scan_ff <= fill_ff))
      else $error("scan past filled entries");
`endif

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking testbench for adaptive_degree_line_prefetcher_unit
// drives hit, miss and fill events, predicts prefetch requests in-line
// depends on adlp_pkg and the prefetcher rtl
module tb_top;

   localparam int DEPTH = adlp_pkg::TABLE_DEPTH_DEFAULT;
   localparam int CYCLE_LIMIT = 4000000;
   localparam logic [adlp_pkg::CSR_IDX_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [adlp_pkg::CSR_IDX_W-1:0] CSR_SPARE_HI = 2'd3;

   typedef struct {
      logic [63:0] base_addr;
      logic [63:0] target_addr;
      logic        fill_level;
      logic        last_of_run;
   } prefetch_req_type;

   typedef struct {
      logic [1:0]  mode;
      logic [63:0] addr;
      logic        was_pf;
      logic [63:0] ev_addr;
      logic        typed;
      logic [63:0] t_base;
      logic [63:0] t_target;
      logic        t_level;
   } event_row_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic [1:0]  req_mode = adlp_pkg::MODE_HIT;
   logic [63:0] req_addr = '0;
   logic        req_fill_was_prefetch = 0;
   logic [63:0] req_evicted_addr = '0;
   logic        rsp_valid;
   logic [63:0] rsp_base_addr;
   logic [63:0] rsp_target_addr;
   logic        rsp_fill_level;
   logic        rsp_last_of_run;
   logic        csr_write_enable = 0;
   logic [adlp_pkg::CSR_IDX_W-1:0]  csr_index = adlp_pkg::CSR_DOUBLE_LIMIT;
   logic [adlp_pkg::CSR_DATA_W-1:0] csr_write_data = '0;

   adaptive_degree_line_prefetcher_unit dut (.*);

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   // predictor state
   logic [63:0] run_line [DEPTH];
   logic [63:0] run_issuer [DEPTH];
   logic        run_is_last [DEPTH];
   logic [6:0]  run_degree [DEPTH];
   logic [6:0]  run_dist [DEPTH];
   int          fill_count = 0;
   int          replace_ptr = 0;
   logic [6:0]  degree = adlp_pkg::DEGREE_RESET;
   logic [3:0]  trig_tenths = adlp_pkg::TRIGGER_RESET;
   logic [6:0]  double_limit = adlp_pkg::DOUBLE_LIMIT_RESET;
   logic [3:0]  trig_cap = adlp_pkg::TRIGGER_CAP_RESET;

   prefetch_req_type pending_requests[$];
   int  mismatches = 0;
   int  cycles = 0;
   int  idle_pct = 0;

   function automatic int next_slot();
      int s;
      if (fill_count < DEPTH) begin
         fill_count++;
         return fill_count - 1;
      end
      s = replace_ptr;
      replace_ptr = (replace_ptr + 1) % DEPTH;
      return s;
   endfunction

   function automatic void record_run(logic [63:0] issuer);
      int trig_dist;
      int s;
      trig_dist = (int'(trig_tenths) * int'(degree)) / 10;
      if (trig_dist > 127) trig_dist = 127;
      for (int j = 1; j <= int'(degree); j++) begin
         s = next_slot();
         run_line[s] = issuer + 64'(j);
         run_issuer[s] = issuer;
         run_is_last[s] = (j == int'(degree));
         run_degree[s] = degree;
         run_dist[s] = 7'(trig_dist);
      end
   endfunction

   function automatic int find_line(logic [63:0] ln);
      for (int i = 0; i < fill_count; i++)
         if (run_line[i] == ln) return i;
      return -1;
   endfunction

   function automatic void predict_event(event_row_type ev);
      logic [63:0] ln, ev_ln, m_line, m_issuer, nb;
      logic [6:0] m_deg, m_dist, d0;
      logic m_last;
      int i, n0, g1;
      prefetch_req_type r;
      ln = ev.addr >> 6;
      ev_ln = ev.ev_addr >> 6;
      n0 = pending_requests.size();
      if (ev.mode == adlp_pkg::MODE_MISS) begin
         r = '{ev.addr, (ln + 64'(degree)) << 6, 1'b1, 1'b1};
         pending_requests.push_back(r);
         record_run(ln);
      end else if (ev.mode == adlp_pkg::MODE_HIT) begin
         i = find_line(ln);
         if (i < 0) return;
         m_line = run_line[i];
         m_issuer = run_issuer[i];
         m_last = run_is_last[i];
         m_deg = run_degree[i];
         m_dist = run_dist[i];
         d0 = degree;
         if (m_line >= m_issuer + 64'(m_deg) - 64'(m_dist)) begin
            nb = m_issuer + 64'(m_deg);
            r = '{nb << 6, (nb + 64'(d0)) << 6, 1'b1, 1'b0};
            pending_requests.push_back(r);
            record_run(nb);
         end
         if (m_last) begin
            r = '{(m_line + 64'd1) << 6, (m_line + 64'(d0)) << 6, 1'b0, 1'b0};
            pending_requests.push_back(r);
            if (degree < double_limit) degree = 7'(degree * 2);
            if (trig_tenths < trig_cap && trig_tenths < adlp_pkg::TRIGGER_MAX)
               trig_tenths++;
         end
         if (pending_requests.size() > n0)
            pending_requests[pending_requests.size() - 1].last_of_run = 1'b1;
      end else if (ev.mode == adlp_pkg::MODE_FILL) begin
         for (int k = 0; k < fill_count; k++)
            if (run_line[k] == ev_ln && run_is_last[k]) begin
               if (degree > 1) degree--;
               if (trig_tenths >= 1) trig_tenths--;
            end
         if (ev.was_pf) begin
            i = find_line(ln);
            if (i >= 0 && run_is_last[i]) begin
               g1 = int'(run_dist[i]) + 1;
               if (g1 > 127) g1 = 127;
               if (g1 > int'(run_degree[i])) run_degree[i] = 7'(g1);
            end
         end
      end
   endfunction

   // response check
   always @(posedge clock) begin
      prefetch_req_type e;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("adaptive_degree_line_prefetcher_unit regression: fail");
         $finish;
      end
      if (!reset && rsp_valid) begin
         if (pending_requests.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected beat base %h", rsp_base_addr);
         end else begin
            e = pending_requests.pop_front();
            if (e.base_addr !== rsp_base_addr || e.target_addr !== rsp_target_addr ||
                e.fill_level !== rsp_fill_level || e.last_of_run !== rsp_last_of_run) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch exp %h %h %b %b got %h %h %b %b",
                           e.base_addr, e.target_addr, e.fill_level, e.last_of_run,
                           rsp_base_addr, rsp_target_addr, rsp_fill_level,
                           rsp_last_of_run);
            end
         end
      end
   end

   task automatic send_event(event_row_type ev);
      int predicted;
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         start <= 0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      start <= 1;
      req_mode <= ev.mode;
      req_addr <= ev.addr;
      req_fill_was_prefetch <= ev.was_pf;
      req_evicted_addr <= ev.ev_addr;
      do @(posedge clock); while (busy);
      predicted = pending_requests.size();
      predict_event(ev);
      if (ev.typed) begin
         if (pending_requests.size() == predicted ||
             pending_requests[predicted].base_addr !== ev.t_base ||
             pending_requests[predicted].target_addr !== ev.t_target ||
             pending_requests[predicted].fill_level !== ev.t_level) begin
            mismatches++;
            if (mismatches <= 10) $display("directed row mismatch addr %h", ev.addr);
         end
      end
   endtask

   task automatic drain();
      start <= 0;
      while (pending_requests.size() != 0) @(posedge clock);
      do @(posedge clock); while (busy);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(logic [adlp_pkg::CSR_IDX_W-1:0] idx,
                            logic [adlp_pkg::CSR_DATA_W-1:0] val);
      csr_write_enable <= 1;
      csr_index <= idx;
      csr_write_data <= val;
      @(posedge clock);
      csr_write_enable <= 0;
      if (idx == adlp_pkg::CSR_DOUBLE_LIMIT) double_limit = val;
      else if (idx == adlp_pkg::CSR_TRIGGER_CAP) trig_cap = val[3:0];
   endtask

   function automatic event_row_type random_event();
      event_row_type ev;
      int pick;
      ev = '{default: '0};
      ev.addr = {$urandom, $urandom};
      ev.ev_addr = {$urandom, $urandom};
      ev.was_pf = 1'($urandom_range(1));
      pick = $urandom_range(99);
      if (pick < 25) ev.mode = adlp_pkg::MODE_MISS;
      else if (pick < 75) ev.mode = adlp_pkg::MODE_HIT;
      else if (pick < 97) ev.mode = adlp_pkg::MODE_FILL;
      else ev.mode = adlp_pkg::MODE_NONE;
      if (fill_count > 0 && $urandom_range(9) < 8) begin
         ev.addr = (run_line[$urandom_range(fill_count - 1)] << 6) | 64'($urandom_range(63));
         if ($urandom_range(1))
            ev.ev_addr = (run_line[$urandom_range(fill_count - 1)] << 6)
                         | 64'($urandom_range(63));
      end
      return ev;
   endfunction

   event_row_type directed [$] = '{
      '{adlp_pkg::MODE_MISS, 64'h0, 1'b0, 64'h0, 1'b1, 64'h0, 64'h40, 1'b1},
      '{adlp_pkg::MODE_HIT, 64'h40, 1'b0, 64'h0, 1'b1, 64'h40, 64'h80, 1'b1},
      '{adlp_pkg::MODE_HIT, 64'h7F, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 0, 0, 0},
      '{adlp_pkg::MODE_HIT, 64'h1234_5678_0000, 1'b0, 64'h0, 1'b0, 0, 0, 0},
      '{adlp_pkg::MODE_NONE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
        64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 0, 0, 0},
      '{adlp_pkg::MODE_MISS, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
        64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 0, 0, 0},
      '{adlp_pkg::MODE_HIT, 64'h0, 1'b0, 64'h0, 1'b0, 0, 0, 0},
      '{adlp_pkg::MODE_HIT, 64'h3F, 1'b0, 64'h0, 1'b0, 0, 0, 0},
      '{adlp_pkg::MODE_FILL, 64'h80, 1'b1, 64'h80, 1'b0, 0, 0, 0},
      '{adlp_pkg::MODE_FILL, 64'hC0, 1'b1, 64'h0, 1'b0, 0, 0, 0},
      '{adlp_pkg::MODE_FILL, 64'h0, 1'b0, 64'hFFFF_FFFF_FFFF_FFC0, 1'b0, 0, 0, 0},
      '{adlp_pkg::MODE_MISS, 64'h1000, 1'b0, 64'h0, 1'b0, 0, 0, 0},
      '{adlp_pkg::MODE_HIT, 64'h1040, 1'b0, 64'h0, 1'b0, 0, 0, 0},
      '{adlp_pkg::MODE_HIT, 64'h1080, 1'b0, 64'h0, 1'b0, 0, 0, 0},
      '{adlp_pkg::MODE_HIT, 64'h10C0, 1'b0, 64'h0, 1'b0, 0, 0, 0},
      '{adlp_pkg::MODE_FILL, 64'h1100, 1'b1, 64'h1100, 1'b0, 0, 0, 0},
      '{adlp_pkg::MODE_FILL, 64'h0, 1'b0, 64'h0, 1'b0, 0, 0, 0}
   };

   initial begin
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      foreach (directed[k]) send_event(directed[k]);
      drain();
      csr_write(adlp_pkg::CSR_DOUBLE_LIMIT, 7'd1);
      csr_write(adlp_pkg::CSR_TRIGGER_CAP, 7'd1);
      csr_write(CSR_SPARE_LO, 7'h7F);
      csr_write(CSR_SPARE_HI, 7'h55);
      for (int phase = 0; phase < 3; phase++) begin
         idle_pct = (phase == 0) ? 26 : (phase == 1) ? 49 : 0;
         for (int k = 0; k < 180; k++) begin
            send_event(random_event());
            if (k == 90) drain();
         end
         drain();
         case (phase)
            0: begin
               csr_write(adlp_pkg::CSR_DOUBLE_LIMIT, 7'd64);
               csr_write(adlp_pkg::CSR_TRIGGER_CAP, 7'd10);
            end
            1: begin
               csr_write(adlp_pkg::CSR_DOUBLE_LIMIT, 7'h7F);
               csr_write(adlp_pkg::CSR_TRIGGER_CAP, 7'h7F);
            end
            default: ;
         endcase
      end
      drain();
      repeat (40) @(posedge clock);
      if (mismatches == 0 && pending_requests.size() == 0)
         $display("adaptive_degree_line_prefetcher_unit regression: pass");
      else
         $display("adaptive_degree_line_prefetcher_unit regression: fail");
      $finish;
   end
endmodule

FILE: sim.f
design/adlp_pkg.sv
design/adlp_table.sv
design/adaptive_degree_line_prefetcher_unit.sv
tb/sv/tb_top.sv
